// ===== hw/rtl/uart_mailbox_registers_core_macros.svh =====
// assertion macros shared by the mailbox rtl
`ifndef UART_MAILBOX_REGISTERS_CORE_MACROS_SVH
`define UART_MAILBOX_REGISTERS_CORE_MACROS_SVH

// clocked assertion, quiet while reset is low
`define UMR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen on a clock edge
`define UMR_ASSERT_NEVER(label, cond, msg) \
	`UMR_ASSERT(label, !(cond), msg)

`endif

// ===== hw/rtl/umr_pkg.sv =====
// types and constants of the uart mailbox register block
package umr_pkg;

	localparam int LANES = 4;

	localparam logic [1:0] KIND_BUS_WRITE = 2'd0;
	localparam logic [1:0] KIND_BUS_READ  = 2'd1;
	localparam logic [1:0] KIND_PARTNER   = 2'd2;

	localparam logic [11:0] SEND_OFFSET   = 12'h000;
	localparam logic [11:0] STATUS_OFFSET = 12'h004;

	localparam logic [2:0] MAX_BYTES = 3'd4;

	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 72;

	typedef struct packed {
		logic        push;
		logic        pop;
		logic [31:0] word;
	} fifo_req_t;

	typedef struct packed {
		logic       nonempty;
		logic       drop;
		logic [1:0] head_lane;
		logic [2:0] pop_cnt;
	} fifo_stat_t;

	typedef struct packed {
		logic        valid;
		logic        is_pop;
		logic [1:0]  pop_lane;
		logic [2:0]  pop_cnt;
		logic        status;
		logic        send_valid;
		logic [31:0] send_word;
		logic        overflow;
	} s2_ctl_t;

endpackage

// ===== hw/rtl/umr_bank_ram.sv =====
// one byte lane of the receive fifo storage, registered read
module umr_bank_ram #(
	parameter int ROWS = 4,
	parameter int RW   = 2
) (
	input  logic          clk,
	input  logic          we,
	input  logic [RW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [RW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [ROWS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/umr_rx_fifo.sv =====
// receive byte fifo: four banked lanes, up to four bytes in or out per transfer
module umr_rx_fifo #(
	parameter int DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  umr_pkg::fifo_req_t    req,
	output umr_pkg::fifo_stat_t   stat,
	output logic [3:0][7:0]       rd_data
);

	import umr_pkg::*;

	localparam int ROWS = (DEPTH + LANES - 1) / LANES;
	localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CW   = $clog2(DEPTH + 1);

	logic [RW-1:0] head_row_q, tail_row_q;
	logic [1:0]    head_lane_q, tail_lane_q;
	logic [CW-1:0] count_q;

	logic [CW-1:0] free;
	logic [2:0]    npush, npop;

	logic [RW-1:0] wr_row [LANES];
	logic [RW-1:0] rd_row [LANES];
	logic [7:0]    wr_byte [LANES];
	logic [LANES-1:0] wr_en;

	logic [2:0]    head_sum, tail_sum;

	function automatic logic [RW-1:0] row_step(input logic [RW-1:0] row, input logic inc);
		logic [RW:0] r;
		r = {1'b0, row} + {{RW{1'b0}}, inc};
		return (r == (RW + 1)'(ROWS)) ? '0 : r[RW-1:0];
	endfunction

	assign free  = CW'(DEPTH) - count_q;
	assign npush = (free >= CW'(MAX_BYTES)) ? MAX_BYTES : free[2:0];
	assign npop  = (count_q >= CW'(MAX_BYTES)) ? MAX_BYTES : count_q[2:0];

	// each lane sees exactly one byte slot of a four-byte window
	always_comb begin
		logic [1:0] wk, rk;
		logic [2:0] ws, rs;
		for (int b = 0; b < LANES; b++) begin
			wk = 2'(b) - tail_lane_q;
			ws = {1'b0, tail_lane_q} + {1'b0, wk};
			wr_row[b]  = row_step(tail_row_q, ws[2]);
			wr_byte[b] = 8'(req.word >> {wk, 3'b000});
			wr_en[b]   = req.push && ({1'b0, wk} < npush);
			rk = 2'(b) - head_lane_q;
			rs = {1'b0, head_lane_q} + {1'b0, rk};
			rd_row[b] = row_step(head_row_q, rs[2]);
		end
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		umr_bank_ram #(
			.ROWS (ROWS),
			.RW   (RW)
		) u_bank (
			.clk   (clk),
			.we    (wr_en[g]),
			.waddr (wr_row[g]),
			.wdata (wr_byte[g]),
			.re    (req.pop),
			.raddr (rd_row[g]),
			.rdata (rd_data[g])
		);
	end

	assign head_sum = {1'b0, head_lane_q} + npop;
	assign tail_sum = {1'b0, tail_lane_q} + npush;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_row_q  <= '0;
			head_lane_q <= '0;
			tail_row_q  <= '0;
			tail_lane_q <= '0;
			count_q     <= '0;
		end else if (req.push) begin
			tail_row_q  <= row_step(tail_row_q, tail_sum[2]);
			tail_lane_q <= tail_sum[1:0];
			count_q     <= count_q + CW'(npush);
		end else if (req.pop) begin
			head_row_q  <= row_step(head_row_q, head_sum[2]);
			head_lane_q <= head_sum[1:0];
			count_q     <= count_q - CW'(npop);
		end
	end

	assign stat.nonempty  = (count_q != '0);
	assign stat.drop      = (npush != MAX_BYTES);
	assign stat.head_lane = head_lane_q;
	assign stat.pop_cnt   = npop;

	`include "uart_mailbox_registers_core_macros.svh"

	`UMR_ASSERT_NEVER(a_count_bound, count_q > CW'(DEPTH), "fifo count above depth")
	`UMR_ASSERT(a_no_drop_with_room, (req.push && free >= CW'(MAX_BYTES)) |-> !stat.drop, "drop with room")
	`UMR_ASSERT(a_pop_count, req.pop |=> (count_q == $past(count_q) - CW'($past(npop))), "pop count slip")

endmodule

// ===== hw/rtl/uart_mailbox_registers_core.sv =====
// top level of the uart mailbox register block
//
//  channel | direction | tdata (low bit up)                              | tuser
//  s_*     | in        | reg_offset, write_data, write_bytes, partner_word | kind
//  m_*     | out       | read_data, send_word, overflow                  | send_valid
//
// one transfer per cycle sustained while m_tready stays high; a result passes through
// the input register, fifo bank read register and result register
// every stage has its own ready, so bubbles close up while the result waits
// reset clears fifo pointers, count, transmit word and valids; fifo bytes are not cleared
module uart_mailbox_registers_core #(
	parameter int FIFO_DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// reg_offset[11:0], write_data[43:12], write_bytes[46:44], partner_word[78:47]
	input  logic [umr_pkg::IN_TDATA_W-1:0]     s_tdata,
	// kind[1:0]
	input  logic [1:0]                         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// read_data[31:0], send_word[63:32], overflow[64]
	output logic [umr_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// send_valid[0]
	output logic [0:0]                         m_tuser
);

	import umr_pkg::*;

	logic        valid_s1;
	logic [1:0]  kind_s1;
	logic [11:0] offset_s1;
	logic [31:0] wdata_s1;
	logic [2:0]  wbytes_s1;
	logic [31:0] pword_s1;

	s2_ctl_t ctl_s2;
	s2_ctl_t ctl_next;

	logic        out_valid_q;
	logic [31:0] read_data_q;
	logic        send_valid_q;
	logic [31:0] send_word_q;
	logic        overflow_q;

	logic [31:0] transmit_word_q;

	logic ready_out, ready_s2, ready_s1, move_s1;
	logic is_write, is_send, is_read, is_status, is_pop, is_push;
	logic [2:0]  wb_clamp;
	logic [31:0] load_word;

	fifo_req_t       req;
	fifo_stat_t      stat;
	logic [3:0][7:0] rd_data;
	logic [31:0]     pop_word;

	assign ready_out = !out_valid_q || m_tready;
	assign ready_s2  = !ctl_s2.valid || ready_out;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign move_s1   = valid_s1 && ready_s2;
	assign s_tready  = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && s_tvalid) begin
			kind_s1   <= s_tuser;
			offset_s1 <= s_tdata[11:0];
			wdata_s1  <= s_tdata[43:12];
			wbytes_s1 <= s_tdata[46:44];
			pword_s1  <= s_tdata[78:47];
		end
	end

	// decode of the item in the input register
	assign is_write  = (kind_s1 == KIND_BUS_WRITE);
	assign is_read   = (kind_s1 == KIND_BUS_READ);
	assign is_send   = is_write && (offset_s1 == SEND_OFFSET);
	assign is_status = is_read && (offset_s1 == STATUS_OFFSET);
	assign is_pop    = is_read && !is_status;
	assign is_push   = (kind_s1 == KIND_PARTNER);

	assign wb_clamp = (wbytes_s1 > MAX_BYTES) ? MAX_BYTES : wbytes_s1;

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			load_word[8*k +: 8] = (3'(k) < wb_clamp) ? wdata_s1[8*k +: 8] : 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transmit_word_q <= '0;
		end else if (move_s1 && is_write && !is_send) begin
			transmit_word_q <= load_word;
		end
	end

	assign req.push = move_s1 && is_push;
	assign req.pop  = move_s1 && is_pop;
	assign req.word = pword_s1;

	umr_rx_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_rx_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.stat    (stat),
		.rd_data (rd_data)
	);

	always_comb begin
		ctl_next.valid      = 1'b1;
		ctl_next.is_pop     = is_pop;
		ctl_next.pop_lane   = stat.head_lane;
		ctl_next.pop_cnt    = is_pop ? stat.pop_cnt : 3'd0;
		ctl_next.status     = is_status && stat.nonempty;
		ctl_next.send_valid = is_send;
		ctl_next.send_word  = is_send ? transmit_word_q : 32'h0;
		ctl_next.overflow   = is_push && stat.drop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (ready_s2) begin
			ctl_s2 <= move_s1 ? ctl_next : '0;
		end
	end

	// byte k of the read word comes from the lane k places after the head
	always_comb begin
		logic [1:0] lane;
		for (int k = 0; k < LANES; k++) begin
			lane = ctl_s2.pop_lane + 2'(k);
			pop_word[8*k +: 8] = (3'(k) < ctl_s2.pop_cnt) ? rd_data[lane] : 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_out) begin
			out_valid_q <= ctl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_out && ctl_s2.valid) begin
			read_data_q  <= ctl_s2.is_pop ? pop_word : {31'h0, ctl_s2.status};
			send_valid_q <= ctl_s2.send_valid;
			send_word_q  <= ctl_s2.send_word;
			overflow_q   <= ctl_s2.overflow;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'h00, overflow_q, send_word_q, read_data_q};
	assign m_tuser  = send_valid_q;

	`include "uart_mailbox_registers_core_macros.svh"

	`UMR_ASSERT(a_send_no_read, (m_tvalid && m_tuser[0]) |-> (m_tdata[31:0] == 32'h0 && !m_tdata[64]), "send with read data")
	`UMR_ASSERT(a_drop_no_read, (m_tvalid && m_tdata[64]) |-> (m_tdata[31:0] == 32'h0), "overflow with read data")
	`UMR_ASSERT(a_stage_advance, move_s1 |=> ctl_s2.valid, "item lost between stages")

endmodule

// ===== bench/tb.sv =====
// self-checking testbench for the uart mailbox register block
`timescale 1ns / 100ps

module tb;
	import umr_pkg::*;

	localparam int RX_DEPTH = 16;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int RANDOM_REQS = 650;
	localparam int HOLD_AFTER = 150;
	localparam int HOLD_CYCLES = 120;

	typedef struct packed {
		logic [1:0]  kind;
		logic [11:0] reg_offset;
		logic [31:0] write_data;
		logic [2:0]  write_bytes;
		logic [31:0] partner_word;
	} mailbox_req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        send_valid;
		logic [31:0] send_word;
		logic        overflow;
	} mailbox_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [0:0] m_tuser;

	// mirror of the block state
	logic [31:0] tx_word;
	logic [7:0]  rx_bytes [RX_DEPTH];
	int          rx_head, rx_tail, rx_count;

	mailbox_req_t pending_reqs[$];
	mailbox_rsp_t expected_rsps[$];
	mailbox_req_t cur_req;
	int gap_left, sent_count;
	int stall_left, cycle_count, results_seen;
	int hold_left;
	bit hold_done;
	int fail_count = 0;

	uart_mailbox_registers_core #(.FIFO_DEPTH(RX_DEPTH)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic mailbox_rsp_t mailbox_step(mailbox_req_t req);
		mailbox_rsp_t rsp;
		logic [2:0] nbytes;
		logic [31:0] w;
		rsp = '0;
		if (req.kind == KIND_BUS_WRITE) begin
			if (req.reg_offset == SEND_OFFSET) begin
				rsp.send_valid = 1'b1;
				rsp.send_word = tx_word;
			end else begin
				nbytes = (req.write_bytes > MAX_BYTES) ? MAX_BYTES : req.write_bytes;
				w = '0;
				for (int k = 0; k < LANES; k++)
					if (k < nbytes)
						w[8*k +: 8] = req.write_data[8*k +: 8];
				tx_word = w;
			end
		end else if (req.kind == KIND_BUS_READ) begin
			if (req.reg_offset == STATUS_OFFSET) begin
				rsp.read_data = (rx_count != 0) ? 32'd1 : 32'd0;
			end else begin
				for (int k = 0; k < LANES && rx_count != 0; k++) begin
					rsp.read_data[8*k +: 8] = rx_bytes[rx_head];
					rx_head = (rx_head + 1) % RX_DEPTH;
					rx_count--;
				end
			end
		end else if (req.kind == KIND_PARTNER) begin
			for (int k = 0; k < LANES; k++) begin
				if (rx_count >= RX_DEPTH) begin
					rsp.overflow = 1'b1;
				end else begin
					rx_bytes[rx_tail] = req.partner_word[8*k +: 8];
					rx_tail = (rx_tail + 1) % RX_DEPTH;
					rx_count++;
				end
			end
		end
		return rsp;
	endfunction

	function automatic mailbox_req_t make_req(logic [1:0] kind, logic [11:0] offset,
			logic [31:0] wdata, logic [2:0] nbytes, logic [31:0] pword);
		mailbox_req_t req;
		req.kind = kind;
		req.reg_offset = offset;
		req.write_data = wdata;
		req.write_bytes = nbytes;
		req.partner_word = pword;
		return req;
	endfunction

	function automatic void add_req(mailbox_req_t req);
		pending_reqs.insert(pending_reqs.size(), req);
	endfunction

	// filling phases favor partner words, draining phases favor pops
	function automatic mailbox_req_t random_req(bit filling);
		mailbox_req_t req;
		int r;
		req.reg_offset = 12'($urandom_range(0, 4095));
		req.write_data = $urandom;
		req.write_bytes = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
			: 3'($urandom_range(1, 4));
		req.partner_word = $urandom;
		r = $urandom_range(0, 99);
		if (r < 5) begin
			req.kind = KIND_UNUSED;
		end else if (r < 30) begin
			req.kind = KIND_BUS_WRITE;
			if ($urandom_range(0, 2) == 0)
				req.reg_offset = SEND_OFFSET;
			else if (req.reg_offset == SEND_OFFSET)
				req.reg_offset = 12'($urandom_range(1, 4095));
		end else if (r < (filling ? 45 : 85)) begin
			req.kind = KIND_BUS_READ;
			if ($urandom_range(0, 3) == 0)
				req.reg_offset = STATUS_OFFSET;
			else if (req.reg_offset == STATUS_OFFSET)
				req.reg_offset = SEND_OFFSET;
		end else begin
			req.kind = KIND_PARTNER;
		end
		return req;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val, act_val);
			fail_count++;
		end
	endtask

	// sender: presents queued requests, predicts on every accepted transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			gap_left <= 0;
			sent_count <= 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_rsps.insert(expected_rsps.size(), mailbox_step(cur_req));
			if (s_tvalid && !s_tready) begin
				// hold the offered item
			end else if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				cur_req = pending_reqs[0];
				pending_reqs.delete(0);
				s_tdata <= {1'b0, cur_req.partner_word, cur_req.write_bytes,
					cur_req.write_data, cur_req.reg_offset};
				s_tuser <= cur_req.kind;
				s_tvalid <= 1'b1;
				gap_left <= (sent_count % 120 < 30) ? 0 : pick_gap();
				sent_count <= sent_count + 1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// one long receiver hold-off so the pipeline backs up into the input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && results_seen >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// receiver: checks each result transfer and drives ready
	always @(posedge clk or negedge arst_n) begin
		mailbox_rsp_t exp_rsp;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
			cycle_count <= 0;
			results_seen <= 0;
		end else begin
			cycle_count <= cycle_count + 1;
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected result, expected none actual %h/%h", $time,
						m_tdata, m_tuser);
					fail_count++;
				end else begin
					exp_rsp = expected_rsps[0];
					expected_rsps.delete(0);
					check_field("read_data", exp_rsp.read_data, m_tdata[31:0]);
					check_field("send_valid", 32'(exp_rsp.send_valid), 32'(m_tuser[0]));
					check_field("send_word", exp_rsp.send_word, m_tdata[63:32]);
					check_field("overflow", 32'(exp_rsp.overflow), 32'(m_tdata[64]));
				end
			end
			if (hold_left != 0) begin
				m_tready <= 1'b0;
			end else if (cycle_count % 256 < 64) begin
				m_tready <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				m_tready <= 1'b0;
			end else begin
				stall_left <= pick_gap();
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		#3_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		int counted;
		mailbox_req_t req;
		tx_word = '0;
		rx_head = 0;
		rx_tail = 0;
		rx_count = 0;
		foreach (rx_bytes[i])
			rx_bytes[i] = '0;

		// empty fifo: status and pop
		add_req(make_req(KIND_BUS_READ, STATUS_OFFSET, '1, 3'd7, '1));
		add_req(make_req(KIND_BUS_READ, 12'h123, '0, 3'd0, '0));
		// send ignores its data; transmit word still at reset value
		add_req(make_req(KIND_BUS_WRITE, SEND_OFFSET, '1, 3'd4, '1));
		add_req(make_req(KIND_BUS_WRITE, 12'hfff, '1, 3'd4, '0));
		add_req(make_req(KIND_BUS_WRITE, SEND_OFFSET, '0, 3'd0, '0));
		// zero byte write clears the transmit word
		add_req(make_req(KIND_BUS_WRITE, 12'h008, 32'hdeadbeef, 3'd0, '0));
		add_req(make_req(KIND_BUS_WRITE, SEND_OFFSET, '0, 3'd4, '0));
		// byte counts above four clamp to four
		add_req(make_req(KIND_BUS_WRITE, 12'h001, 32'ha5a5a5a5, 3'd7, '0));
		add_req(make_req(KIND_BUS_WRITE, SEND_OFFSET, '0, 3'd0, '0));
		add_req(make_req(KIND_BUS_WRITE, 12'h002, 32'h12345678, 3'd1, '0));
		add_req(make_req(KIND_BUS_WRITE, SEND_OFFSET, '0, 3'd0, '0));
		add_req(make_req(KIND_BUS_WRITE, 12'h800, 32'h9abcdef0, 3'd2, '0));
		add_req(make_req(KIND_BUS_WRITE, 12'h7fc, 32'h0fedcba9, 3'd3, '0));
		add_req(make_req(KIND_BUS_WRITE, SEND_OFFSET, '0, 3'd0, '0));
		// unused kind does nothing
		add_req(make_req(KIND_UNUSED, '1, '1, 3'd7, '1));
		// fill the fifo, then overflow it
		add_req(make_req(KIND_PARTNER, '0, '0, 3'd0, 32'hffffffff));
		add_req(make_req(KIND_PARTNER, '1, '1, 3'd7, 32'h00000000));
		add_req(make_req(KIND_PARTNER, '0, '0, 3'd0, 32'h01020304));
		add_req(make_req(KIND_PARTNER, '0, '0, 3'd0, 32'h55aa55aa));
		add_req(make_req(KIND_PARTNER, '0, '0, 3'd0, 32'hcafef00d));
		add_req(make_req(KIND_BUS_READ, STATUS_OFFSET, '0, 3'd0, '0));
		// drain completely, then pop once more
		add_req(make_req(KIND_BUS_READ, 12'hfff, '0, 3'd0, '0));
		add_req(make_req(KIND_BUS_READ, SEND_OFFSET, '0, 3'd0, '0));
		add_req(make_req(KIND_BUS_READ, 12'h005, '0, 3'd0, '0));
		add_req(make_req(KIND_BUS_READ, 12'h003, '0, 3'd0, '0));
		add_req(make_req(KIND_BUS_READ, 12'h040, '0, 3'd0, '0));

		counted = 0;
		while (counted < RANDOM_REQS) begin
			req = random_req((counted / 40) % 2 == 0);
			add_req(req);
			if (req.kind != KIND_UNUSED)
				counted++;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || s_tvalid || expected_rsps.size() != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/umr_pkg.sv
hw/rtl/umr_bank_ram.sv
hw/rtl/umr_rx_fifo.sv
hw/rtl/uart_mailbox_registers_core.sv
bench/tb.sv
